[hw/rtl/trading_signal_decider_macros.svh]
// assertion helpers for tsd_back, sampled on i_clk and muted in reset
`ifndef TRADING_SIGNAL_DECIDER_MACROS_SVH
`define TRADING_SIGNAL_DECIDER_MACROS_SVH

// same-cycle implication
`define TSD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tsd assertion failed");

// next-cycle implication
`define TSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tsd assertion failed");

`endif

[hw/rtl/tsd_pkg.sv]
package tsd_pkg;

    localparam int unsigned PRICE_W     = 16;
    localparam int unsigned ORD_W       = 64;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned IN_TDATA_W  = 56;
    localparam int unsigned OUT_TDATA_W = 72;

    // splitmix64 constants
    localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B   = 64'h94d049bb133111eb;
    localparam int unsigned MIX_SHIFT_A = 30;
    localparam int unsigned MIX_SHIFT_B = 27;
    localparam int unsigned MIX_SHIFT_C = 31;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AGENT_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_PRICE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_UNITS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SEED       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AGENT_NUMBER    = 3'd4;

    typedef enum logic [2:0] {
        MODE_NOISE     = 3'd0,
        MODE_MOMENTUM  = 3'd1,
        MODE_MEAN_REV  = 3'd2,
        MODE_INFORMED  = 3'd3,
        MODE_LIQ_TAKER = 3'd4
    } t_mode;

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    // one decided tick on its way from front to back
    typedef struct packed {
        logic             draw;     // side comes from a random draw
        logic             side;     // fixed side when no draw
        logic [ORD_W-1:0] ordinal;
    } t_cmd;

endpackage

[hw/rtl/trading_signal_decider.sv]
// trading signal decider: takes one decision tick per input beat (optional last trade,
// best bid and best ask) and, under the configured agent mode, may choose a buy or sell
// side; an output beat carries the side and the running tick ordinal and only appears
// when a side was chosen. the front classifies a tick in the cycle it is accepted and
// counts every tick; it takes a beat every cycle while the queue (QUEUE_DEPTH entries)
// has room and stalls the input only when that queue is full. a tick with a fixed side
// goes from the head of the queue into the output register once the back end is idle
// and that register is free; a tick that needs a random draw (noise, liquidity taker)
// is popped into the splitmix64 mixer and reaches the output register once the mixer is
// done; the mixer walks its two 64-bit multiplies through a single 32x32 multiplier,
// three partial products each, and the back end takes no new tick until the draw is in
// the output register. a full output register holds the back end until the beat is taken.
// after reset, and after any write to the seed or agent number register, the back end
// reseeds the random state through the same mixer before its next tick; input beats are
// still taken meanwhile and their results follow once the seed is ready. configuration
// must be written only while no tick is in flight; the block itself does not enforce it.
module trading_signal_decider #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port, index 0 mode, 1 reference, 2 threshold, 3 seed, 4 agent
    input  logic                            i_cfg_we,
    input  logic [tsd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tsd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // decision tick in
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // has_last_trade, last_trade[15:0], has_bid, bid_price[15:0], has_ask, ask_price[15:0],
    // zero pad
    input  logic [tsd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // order decision out
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // order_side (0 buy, 1 sell), tick_ordinal[63:0], zero pad
    output logic [tsd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import tsd_pkg::*;

    logic q_full;
    logic q_push;
    t_cmd q_in_cmd;
    logic q_valid;
    t_cmd q_out_cmd;
    logic q_pop;

    // front: config for the rules, tick counter, classification
    tsd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_tdata     (s_axis_tdata),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_cmd       (q_in_cmd)
    );

    // decoupling queue between classification and the draw engine
    tsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_out_cmd),
        .i_pop   (q_pop)
    );

    // back: random state, seeding, draws and the output register
    tsd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_out_cmd),
        .o_pop       (q_pop),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata)
    );

endmodule

[hw/rtl/tsd_front.sv]
module tsd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tsd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tsd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [tsd_pkg::IN_TDATA_W-1:0] i_tdata,
    input  logic                          i_q_full,
    output logic                          o_push,
    output tsd_pkg::t_cmd                 o_cmd
);
    import tsd_pkg::*;

    t_mode                r_mode;
    logic [PRICE_W-1:0]   r_ref;
    logic [PRICE_W-1:0]   r_thr;
    logic [ORD_W-1:0]     r_count;
    logic [ORD_W-1:0]     n_count;

    logic                 has_last, has_bid, has_ask;
    logic [PRICE_W-1:0]   last_px, bid_px, ask_px;
    logic [PRICE_W:0]     ref_plus_thr, last_plus_thr, bid_plus_thr;
    logic                 chosen, draw, side, accept;

    assign has_last = i_tdata[0];
    assign last_px  = i_tdata[16:1];
    assign has_bid  = i_tdata[17];
    assign bid_px   = i_tdata[33:18];
    assign has_ask  = i_tdata[34];
    assign ask_px   = i_tdata[50:35];

    // one bit wider so the sums cannot wrap
    assign ref_plus_thr  = {1'b0, r_ref} + {1'b0, r_thr};
    assign last_plus_thr = {1'b0, last_px} + {1'b0, r_thr};
    assign bid_plus_thr  = {1'b0, bid_px} + {1'b0, r_thr};

    always_comb begin
        chosen = 1'b0;
        draw   = 1'b0;
        side   = SIDE_BUY;
        unique case (r_mode)
            MODE_NOISE: begin
                chosen = 1'b1;
                draw   = 1'b1;
            end
            MODE_MOMENTUM: begin
                if (has_last) begin
                    if ({1'b0, last_px} >= ref_plus_thr) begin
                        chosen = 1'b1;
                        side   = SIDE_BUY;
                    end else if (last_plus_thr <= {1'b0, r_ref}) begin
                        chosen = 1'b1;
                        side   = SIDE_SELL;
                    end
                end
            end
            MODE_MEAN_REV: begin
                if (has_bid && has_ask) begin
                    if ({1'b0, ask_px} >= ref_plus_thr) begin
                        chosen = 1'b1;
                        side   = SIDE_SELL;
                    end else if (bid_plus_thr <= {1'b0, r_ref}) begin
                        chosen = 1'b1;
                        side   = SIDE_BUY;
                    end
                end
            end
            MODE_INFORMED: begin
                if (has_ask && (ask_px < r_ref)) begin
                    chosen = 1'b1;
                    side   = SIDE_BUY;
                end else if (has_bid && (bid_px > r_ref)) begin
                    chosen = 1'b1;
                    side   = SIDE_SELL;
                end
            end
            MODE_LIQ_TAKER: begin
                // spread within threshold, a crossed book counts as within
                if (has_bid && has_ask && ({1'b0, ask_px} <= bid_plus_thr)) begin
                    chosen = 1'b1;
                    draw   = 1'b1;
                end
            end
            default: begin
                chosen = 1'b0;
            end
        endcase
    end

    assign o_ready       = !i_q_full;
    assign accept        = i_valid && o_ready;
    assign n_count       = r_count + ORD_W'(1);
    assign o_push        = accept && chosen;
    assign o_cmd.draw    = draw;
    assign o_cmd.side    = side;
    assign o_cmd.ordinal = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_NOISE;
            r_ref   <= '0;
            r_thr   <= PRICE_W'(1);
            r_count <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_AGENT_MODE) begin
                    r_mode <= t_mode'(i_cfg_data[2:0]);
                end
                if (i_cfg_index == REG_REFERENCE_PRICE) begin
                    r_ref <= i_cfg_data[PRICE_W-1:0];
                end
                if (i_cfg_index == REG_THRESHOLD_UNITS) begin
                    r_thr <= i_cfg_data[PRICE_W-1:0];
                end
            end
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

endmodule

[hw/rtl/tsd_queue.sv]
module tsd_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tsd_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output tsd_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    import tsd_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[hw/rtl/tsd_mix.sv]
module tsd_mix (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_value,
    output logic        o_done,
    output logic [63:0] o_result
);
    import tsd_pkg::*;

    // each 64-bit multiply takes three passes of one 32x32 multiplier:
    // low x low, high x low, low x high
    typedef enum logic [2:0] {
        M_IDLE, M_A0, M_A1, M_A2, M_B0, M_B1, M_B2
    } t_mstep;

    t_mstep      r_step;
    logic [63:0] r_x;
    logic [63:0] r_p0;
    logic [31:0] r_cross;
    logic [63:0] r_res;
    logic        r_done;

    logic [63:0] konst;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [31:0] cross_sum;
    logic [63:0] prod;
    logic [63:0] seeded;

    always_comb begin
        konst = ((r_step == M_B0) || (r_step == M_B1) || (r_step == M_B2)) ? MIX_MUL_B
                                                                          : MIX_MUL_A;
        mul_a = ((r_step == M_A1) || (r_step == M_B1)) ? r_x[63:32] : r_x[31:0];
        mul_b = ((r_step == M_A2) || (r_step == M_B2)) ? konst[63:32] : konst[31:0];
    end

    assign mul_p     = {32'b0, mul_a} * {32'b0, mul_b};
    assign cross_sum = r_cross + mul_p[31:0];
    assign prod      = r_p0 + {cross_sum, 32'b0};
    assign seeded    = i_value + GOLDEN_STEP;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= M_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_step)
                M_IDLE: begin
                    if (i_start) begin
                        r_x    <= seeded ^ (seeded >> MIX_SHIFT_A);
                        r_step <= M_A0;
                    end
                end
                M_A0: begin
                    r_p0   <= mul_p;
                    r_step <= M_A1;
                end
                M_A1: begin
                    r_cross <= mul_p[31:0];
                    r_step  <= M_A2;
                end
                M_A2: begin
                    r_x    <= prod ^ (prod >> MIX_SHIFT_B);
                    r_step <= M_B0;
                end
                M_B0: begin
                    r_p0   <= mul_p;
                    r_step <= M_B1;
                end
                M_B1: begin
                    r_cross <= mul_p[31:0];
                    r_step  <= M_B2;
                end
                M_B2: begin
                    r_res  <= prod ^ (prod >> MIX_SHIFT_C);
                    r_done <= 1'b1;
                    r_step <= M_IDLE;
                end
                default: begin
                    r_step <= M_IDLE;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

[hw/rtl/tsd_back.sv]
`include "trading_signal_decider_macros.svh"

module tsd_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tsd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tsd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_q_valid,
    input  tsd_pkg::t_cmd                  i_q_cmd,
    output logic                           o_pop,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [tsd_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import tsd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE, S_SEED, S_DRAW, S_HOLD
    } t_state;

    t_state           r_state;
    logic [63:0]      r_seed;
    logic [63:0]      r_agent;
    logic [63:0]      r_rs;
    logic             r_seed_pend;
    logic [ORD_W-1:0] r_ord;
    logic             r_side;
    logic             r_out_valid;
    logic             r_out_side;
    logic [ORD_W-1:0] r_out_ord;

    logic             out_free;
    logic             out_load;
    logic             seed_write;
    logic             mix_start;
    logic [63:0]      mix_value;
    logic [63:0]      draw_state;
    logic             mix_done;
    logic [63:0]      mix_result;

    assign out_free   = !r_out_valid || i_m_tready;
    assign seed_write = i_cfg_we &&
                        ((i_cfg_index == REG_BASE_SEED) || (i_cfg_index == REG_AGENT_NUMBER));
    assign draw_state = r_rs + GOLDEN_STEP;
    assign mix_start  = (r_state == S_IDLE) && (r_seed_pend || (i_q_valid && i_q_cmd.draw));
    assign mix_value  = r_seed_pend ? (r_seed ^ r_agent) : draw_state;
    assign o_pop      = (r_state == S_IDLE) && !r_seed_pend && i_q_valid &&
                        (i_q_cmd.draw || out_free);
    // output register takes a new beat this cycle
    assign out_load   = ((r_state == S_IDLE) && !r_seed_pend && i_q_valid &&
                         !i_q_cmd.draw && out_free) ||
                        ((r_state == S_DRAW) && mix_done && out_free) ||
                        ((r_state == S_HOLD) && out_free);

    tsd_mix u_mix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mix_start),
        .i_value  (mix_value),
        .o_done   (mix_done),
        .o_result (mix_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seed      <= '0;
            r_agent     <= '0;
            r_seed_pend <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            // a fresh seed write always wins over the clear
            if (seed_write) begin
                r_seed_pend <= 1'b1;
            end else if ((r_state == S_IDLE) && r_seed_pend) begin
                r_seed_pend <= 1'b0;
            end
            if (i_cfg_we && (i_cfg_index == REG_BASE_SEED)) begin
                r_seed <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_index == REG_AGENT_NUMBER)) begin
                r_agent <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    priority if (r_seed_pend) begin
                        r_state <= S_SEED;
                    end else if (i_q_valid && i_q_cmd.draw) begin
                        r_rs    <= draw_state;
                        r_ord   <= i_q_cmd.ordinal;
                        r_state <= S_DRAW;
                    end else if (i_q_valid && out_free) begin
                        r_out_side <= i_q_cmd.side;
                        r_out_ord  <= i_q_cmd.ordinal;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_SEED: begin
                    if (mix_done) begin
                        r_rs    <= mix_result;
                        r_state <= S_IDLE;
                    end
                end
                S_DRAW: begin
                    if (mix_done) begin
                        if (out_free) begin
                            r_out_side <= mix_result[0];
                            r_out_ord  <= r_ord;
                            r_state    <= S_IDLE;
                        end else begin
                            r_side  <= mix_result[0];
                            r_state <= S_HOLD;
                        end
                    end
                end
                S_HOLD: begin
                    if (out_free) begin
                        r_out_side <= r_side;
                        r_out_ord  <= r_ord;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OUT_TDATA_W - ORD_W - 1)'(0), r_out_ord, r_out_side};

    `TSD_ASSERT_NOW(a_done_while_busy, mix_done, (r_state == S_SEED) || (r_state == S_DRAW))
    `TSD_ASSERT_NEXT(a_state_held, (r_state == S_DRAW) || (r_state == S_HOLD), $stable(r_rs))
    `TSD_ASSERT_NEXT(a_draw_pop, o_pop && i_q_cmd.draw, r_state == S_DRAW)

endmodule
